/* sv/ddm_pkg.sv */
// ----------------------------------------------------------------------------
// ddm_pkg
// Shared types, constants and duty tables for the differential drive mixer.
// ----------------------------------------------------------------------------
package ddm_pkg;

    localparam int IN_W          = 10;
    localparam int DUTY_W        = 10;
    localparam int STORED_POINTS = 5;
    localparam int IDX_W         = 3;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = 2;

    localparam logic LANE_RIGHT = 1'b0;
    localparam logic LANE_LEFT  = 1'b1;

    localparam logic [DUTY_W-1:0] RIGHT_TAB [STORED_POINTS] = '{
        10'd139, 10'd154, 10'd198, 10'd335, 10'd600
    };
    localparam logic [DUTY_W-1:0] LEFT_TAB [STORED_POINTS] = '{
        10'd187, 10'd194, 10'd235, 10'd390, 10'd750
    };

    // Classification of one item, carried from the front end to the back end.
    typedef struct packed {
        logic scaled;
        logic small_right;
        logic sign_r;
        logic sign_l;
    } ddm_ctl_t;

    typedef struct packed {
        logic neg_r;
        logic neg_l;
    } ddm_dir_t;

    typedef struct packed {
        logic a_valid;
        logic b_valid;
    } ddm_front_stat_t;

    // Table read with the index held to the stored entries.
    function automatic logic [DUTY_W-1:0] tab_at(input logic lane, input int idx);
        int k;
        k = idx;
        if (k > STORED_POINTS - 1)
        begin
            k = STORED_POINTS - 1;
        end
        if (k < 0)
        begin
            k = 0;
        end
        if (lane == LANE_LEFT)
        begin
            return LEFT_TAB[IDX_W'(k)];
        end
        return RIGHT_TAB[IDX_W'(k)];
    endfunction

endpackage

/* sv/ddm_front.sv */
// ----------------------------------------------------------------------------
// ddm_front
// Forms the mixing products, then classifies each item as spin, plain or
// scaled and prepares the wheel magnitudes and the operands of the divider.
// ----------------------------------------------------------------------------
module ddm_front #(
    parameter int FRAC_BITS = 8,
    parameter int NW        = 21
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [ddm_pkg::IN_W-1:0]   turn,
    input  logic signed [ddm_pkg::IN_W-1:0]   forward,
    output ddm_pkg::ddm_front_stat_t          stat,
    output logic                              push,
    output ddm_pkg::ddm_ctl_t                 ctl,
    output logic [NW-1:0]                     num,
    output logic [NW-1:0]                     den,
    output logic [FRAC_BITS:0]                mag_r,
    output logic [FRAC_BITS:0]                mag_l
);

    localparam int PW  = NW + 1;
    localparam int W1  = NW - 9;
    localparam int F1  = FRAC_BITS + 1;
    localparam int ONE = 1 << FRAC_BITS;
    localparam int CW  = (NW > 2 * FRAC_BITS + 1) ? NW : 2 * FRAC_BITS + 1;
    localparam int TW  = (F1 > ddm_pkg::IN_W) ? F1 : ddm_pkg::IN_W;

    localparam logic signed [W1-1:0] ONE_S  = W1'(ONE);
    localparam logic [F1-1:0]        ONE_M  = F1'(ONE);
    localparam logic [CW-1:0]        ONE_SQ = CW'(1) << (2 * FRAC_BITS);

    // Stage A: products
    logic signed [W1-1:0] turn_x;
    logic signed [W1-1:0] dr;
    logic signed [W1-1:0] dl;
    logic signed [PW-1:0] pr_c;
    logic signed [PW-1:0] pl_c;

    logic                           va_reg;
    logic                           spin_a_reg;
    logic signed [ddm_pkg::IN_W-1:0] turn_a_reg;
    logic signed [PW-1:0]           pr_a_reg;
    logic signed [PW-1:0]           pl_a_reg;

    assign turn_x = W1'(turn);
    assign dr     = ONE_S - turn_x;
    assign dl     = ONE_S + turn_x;
    assign pr_c   = forward * dr;
    assign pl_c   = forward * dl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            spin_a_reg <= (forward == '0);
            turn_a_reg <= turn;
            pr_a_reg   <= pr_c;
            pl_a_reg   <= pl_c;
        end
    end

    // Stage B: magnitudes and classification
    logic [NW-1:0]            ar;
    logic [NW-1:0]            al;
    logic [NW-1:0]            big;
    logic [ddm_pkg::IN_W-1:0] at;
    logic [F1-1:0]            spin_m;
    logic                     scaled;

    ddm_pkg::ddm_ctl_t  ctl_next;
    logic [F1-1:0]      mag_r_next;
    logic [F1-1:0]      mag_l_next;

    logic               vb_reg;
    ddm_pkg::ddm_ctl_t  ctl_reg;
    logic [NW-1:0]      num_reg;
    logic [NW-1:0]      den_reg;
    logic [F1-1:0]      mag_r_reg;
    logic [F1-1:0]      mag_l_reg;

    always_comb
    begin
        ar     = pr_a_reg[PW-1] ? NW'(-pr_a_reg) : NW'(pr_a_reg);
        al     = pl_a_reg[PW-1] ? NW'(-pl_a_reg) : NW'(pl_a_reg);
        big    = (ar > al) ? ar : al;
        at     = turn_a_reg[ddm_pkg::IN_W-1] ? ddm_pkg::IN_W'(-turn_a_reg)
                                             : ddm_pkg::IN_W'(turn_a_reg);
        spin_m = (TW'(at) > TW'(ONE_M)) ? ONE_M : F1'(at);
        scaled = !spin_a_reg && (CW'(big) > ONE_SQ);

        ctl_next.scaled      = scaled;
        ctl_next.small_right = (ar < al);
        if (spin_a_reg)
        begin
            ctl_next.sign_r = !turn_a_reg[ddm_pkg::IN_W-1] && (turn_a_reg != '0);
            ctl_next.sign_l = turn_a_reg[ddm_pkg::IN_W-1];
            mag_r_next      = spin_m;
            mag_l_next      = spin_m;
        end
        else
        begin
            ctl_next.sign_r = pr_a_reg[PW-1];
            ctl_next.sign_l = pl_a_reg[PW-1];
            mag_r_next      = F1'(ar >> FRAC_BITS);
            mag_l_next      = F1'(al >> FRAC_BITS);
            // When scaled, the larger wheel lands exactly on full speed and
            // the smaller one is filled in by the divider.
            if (scaled)
            begin
                mag_r_next = ONE_M;
                mag_l_next = ONE_M;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else
        begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (va_reg)
        begin
            ctl_reg   <= ctl_next;
            num_reg   <= (ar < al) ? ar : al;
            den_reg   <= big;
            mag_r_reg <= mag_r_next;
            mag_l_reg <= mag_l_next;
        end
    end

    assign stat.a_valid = va_reg;
    assign stat.b_valid = vb_reg;
    assign push         = vb_reg;
    assign ctl          = ctl_reg;
    assign num          = num_reg;
    assign den          = den_reg;
    assign mag_r        = mag_r_reg;
    assign mag_l        = mag_l_reg;

endmodule

/* sv/ddm_fifo.sv */
// ----------------------------------------------------------------------------
// ddm_fifo
// Short queue between the front end and the back end, with a registered
// read port.
// ----------------------------------------------------------------------------
module ddm_fifo #(
    parameter int WIDTH = 54
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           din,
    input  logic                       pop,
    output logic [WIDTH-1:0]           dout,
    output logic                       dout_valid,
    output logic [ddm_pkg::FIFO_AW:0]  count
);

    logic [WIDTH-1:0]            mem [ddm_pkg::FIFO_DEPTH];
    logic [ddm_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [ddm_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [ddm_pkg::FIFO_AW:0]   count_reg;
    logic [ddm_pkg::FIFO_AW:0]   count_next;
    logic [WIDTH-1:0]            dout_reg;
    logic                        dout_valid_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            dout_valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg      <= count_next;
            dout_valid_reg <= pop;
        end
    end

    // The popped item is presented on the cycle after the pop.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
        if (pop)
        begin
            dout_reg <= mem[rd_ptr_reg];
        end
    end

    assign dout       = dout_reg;
    assign dout_valid = dout_valid_reg;
    assign count      = count_reg;

endmodule

/* sv/ddm_div.sv */
// ----------------------------------------------------------------------------
// ddm_div
// Pipelined restoring divider, one quotient bit a stage, giving the smaller
// wheel speed as a fraction of the larger one; resolves magnitudes and signs.
// ----------------------------------------------------------------------------
module ddm_div #(
    parameter int FRAC_BITS = 8,
    parameter int NW        = 21
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  ddm_pkg::ddm_ctl_t  ctl,
    input  logic [NW-1:0]      num,
    input  logic [NW-1:0]      den,
    input  logic [FRAC_BITS:0] mag_r,
    input  logic [FRAC_BITS:0] mag_l,
    output logic               out_valid,
    output ddm_pkg::ddm_dir_t  dir,
    output logic [FRAC_BITS:0] mag_r_out,
    output logic [FRAC_BITS:0] mag_l_out
);

    localparam int F1 = FRAC_BITS + 1;

    logic               v_reg   [0:FRAC_BITS];
    logic [NW-1:0]      rem_reg [0:FRAC_BITS];
    logic [NW-1:0]      den_reg [0:FRAC_BITS];
    logic [F1-1:0]      q_reg   [0:FRAC_BITS];
    ddm_pkg::ddm_ctl_t  ctl_reg [0:FRAC_BITS];
    logic [F1-1:0]      mr_reg  [0:FRAC_BITS];
    logic [F1-1:0]      ml_reg  [0:FRAC_BITS];

    logic [NW-1:0]      rem_next [0:FRAC_BITS];
    logic [F1-1:0]      q_next   [0:FRAC_BITS];

    // The first stage decides the integer bit (numerator never exceeds the
    // divisor); each later stage doubles the remainder and takes one bit.
    always_comb
    begin
        logic [NW:0] cand;
        logic [NW:0] dext;
        logic        ge;
        for (int k = 0; k <= FRAC_BITS; k++)
        begin
            if (k == 0)
            begin
                cand = {1'b0, num};
                dext = {1'b0, den};
            end
            else
            begin
                cand = {rem_reg[k-1], 1'b0};
                dext = {1'b0, den_reg[k-1]};
            end
            ge          = (cand >= dext);
            rem_next[k] = ge ? NW'(cand - dext) : NW'(cand);
            if (k == 0)
            begin
                q_next[k] = F1'(ge);
            end
            else
            begin
                q_next[k] = {q_reg[k-1][FRAC_BITS-1:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= FRAC_BITS; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= FRAC_BITS; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= rem_next[0];
        q_reg[0]   <= q_next[0];
        den_reg[0] <= den;
        ctl_reg[0] <= ctl;
        mr_reg[0]  <= mag_r;
        ml_reg[0]  <= mag_l;
        for (int k = 1; k <= FRAC_BITS; k++)
        begin
            rem_reg[k] <= rem_next[k];
            q_reg[k]   <= q_next[k];
            den_reg[k] <= den_reg[k-1];
            ctl_reg[k] <= ctl_reg[k-1];
            mr_reg[k]  <= mr_reg[k-1];
            ml_reg[k]  <= ml_reg[k-1];
        end
    end

    logic [F1-1:0]     mr;
    logic [F1-1:0]     ml;
    ddm_pkg::ddm_ctl_t c;

    always_comb
    begin
        c  = ctl_reg[FRAC_BITS];
        mr = mr_reg[FRAC_BITS];
        ml = ml_reg[FRAC_BITS];
        if (c.scaled)
        begin
            if (c.small_right)
            begin
                mr = q_reg[FRAC_BITS];
            end
            else
            begin
                ml = q_reg[FRAC_BITS];
            end
        end
    end

    // A speed that truncates to zero counts as forward.
    assign dir.neg_r = c.sign_r && (mr != '0);
    assign dir.neg_l = c.sign_l && (ml != '0);
    assign mag_r_out = mr;
    assign mag_l_out = ml;
    assign out_valid = v_reg[FRAC_BITS];

endmodule

/* sv/ddm_duty.sv */
// ----------------------------------------------------------------------------
// ddm_duty
// Maps each wheel magnitude to a PWM duty by linear interpolation between
// the points of that wheel's table, in three registered steps.
// ----------------------------------------------------------------------------
module ddm_duty #(
    parameter int FRAC_BITS    = 8,
    parameter int TABLE_POINTS = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  ddm_pkg::ddm_dir_t           dir,
    input  logic [FRAC_BITS:0]          mag_r,
    input  logic [FRAC_BITS:0]          mag_l,
    output logic                        out_valid,
    output ddm_pkg::ddm_dir_t           dir_out,
    output logic [ddm_pkg::DUTY_W-1:0]  right_duty,
    output logic [ddm_pkg::DUTY_W-1:0]  left_duty
);

    localparam int F1   = FRAC_BITS + 1;
    localparam int SEGW = $clog2(TABLE_POINTS);
    localparam int SW   = F1 + SEGW;
    localparam int DFW  = ddm_pkg::DUTY_W + 1;
    localparam int PRW  = DFW + FRAC_BITS + 1;
    localparam int SUMW = ddm_pkg::DUTY_W + 2;
    localparam int ONE  = 1 << FRAC_BITS;

    localparam logic signed [PRW-1:0] ROUND = PRW'(ONE - 1);

    logic [F1-1:0] mag_in [2];

    assign mag_in[0] = mag_r;
    assign mag_in[1] = mag_l;

    // Step 1: segment, fraction and the two table points
    logic [ddm_pkg::DUTY_W-1:0] base_next [2];
    logic signed [DFW-1:0]      diff_next [2];
    logic [FRAC_BITS-1:0]       frac_next [2];

    always_comb
    begin
        logic [SW-1:0]              s;
        logic [SEGW-1:0]            seg;
        logic [ddm_pkg::DUTY_W-1:0] upper;
        for (int l = 0; l < 2; l++)
        begin
            upper        = '0;
            s            = SW'(mag_in[l]) * SW'(TABLE_POINTS - 1);
            seg          = SEGW'(s >> FRAC_BITS);
            frac_next[l] = s[FRAC_BITS-1:0];
            if (int'(seg) >= TABLE_POINTS - 1)
            begin
                base_next[l] = ddm_pkg::tab_at(1'(l), TABLE_POINTS - 1);
                diff_next[l] = '0;
            end
            else
            begin
                base_next[l] = ddm_pkg::tab_at(1'(l), int'(seg));
                upper        = ddm_pkg::tab_at(1'(l), int'(seg) + 1);
                diff_next[l] = $signed({1'b0, upper}) - $signed({1'b0, base_next[l]});
            end
        end
    end

    logic                       v1_reg;
    ddm_pkg::ddm_dir_t          dir1_reg;
    logic [ddm_pkg::DUTY_W-1:0] base1_reg [2];
    logic signed [DFW-1:0]      diff1_reg [2];
    logic [FRAC_BITS-1:0]       frac1_reg [2];

    // Step 2: slope times fraction
    logic                       v2_reg;
    ddm_pkg::ddm_dir_t          dir2_reg;
    logic [ddm_pkg::DUTY_W-1:0] base2_reg [2];
    logic signed [PRW-1:0]      prod2_reg [2];

    // Step 3: truncating scale-down and sum
    logic [ddm_pkg::DUTY_W-1:0] duty_next [2];

    always_comb
    begin
        logic signed [PRW-1:0]  adj;
        logic signed [PRW-1:0]  quo;
        logic signed [SUMW-1:0] sum;
        for (int l = 0; l < 2; l++)
        begin
            // Bias negative products so the shift truncates toward zero.
            adj = prod2_reg[l] + ((prod2_reg[l] < 0) ? ROUND : PRW'(0));
            quo = adj >>> FRAC_BITS;
            sum = $signed({2'b00, base2_reg[l]}) + SUMW'(quo);
            duty_next[l] = (sum < 0) ? '0 : sum[ddm_pkg::DUTY_W-1:0];
        end
    end

    logic                       v3_reg;
    ddm_pkg::ddm_dir_t          dir3_reg;
    logic [ddm_pkg::DUTY_W-1:0] duty3_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dir1_reg <= dir;
        dir2_reg <= dir1_reg;
        dir3_reg <= dir2_reg;
        for (int l = 0; l < 2; l++)
        begin
            base1_reg[l] <= base_next[l];
            diff1_reg[l] <= diff_next[l];
            frac1_reg[l] <= frac_next[l];
            base2_reg[l] <= base1_reg[l];
            prod2_reg[l] <= diff1_reg[l] * $signed({1'b0, frac1_reg[l]});
            duty3_reg[l] <= duty_next[l];
        end
    end

    assign out_valid  = v3_reg;
    assign dir_out    = dir3_reg;
    assign right_duty = duty3_reg[0];
    assign left_duty  = duty3_reg[1];

endmodule

/* sv/diff_drive_mix_to_pwm.sv */
// ----------------------------------------------------------------------------
// diff_drive_mix_to_pwm
// Path: two front stages, the queue (a write, then a registered read),
// FRAC_BITS+1 divider stages and three table stages, after which done
// pulses. Throughput: one item per cycle while busy is low, through the
// one-bit-a-stage divider pipeline; results cannot be held off.
// Reset clears all valid bits and queue pointers at once; no clearing pass.
// ----------------------------------------------------------------------------
module diff_drive_mix_to_pwm #(
    parameter int FRAC_BITS    = 8,
    parameter int TABLE_POINTS = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [ddm_pkg::IN_W-1:0]   turn,
    input  logic signed [ddm_pkg::IN_W-1:0]   forward,
    output logic                              done,
    output logic [ddm_pkg::DUTY_W-1:0]        right_duty,
    output logic [ddm_pkg::DUTY_W-1:0]        left_duty,
    output logic                              right_backward,
    output logic                              left_backward
);

    localparam int W1   = ((FRAC_BITS > 9) ? FRAC_BITS : 9) + 3;
    localparam int NW   = W1 + 9;
    localparam int F1   = FRAC_BITS + 1;
    localparam int CTLW = $bits(ddm_pkg::ddm_ctl_t);
    localparam int EW   = CTLW + 2 * NW + 2 * F1;
    localparam int OCW  = ddm_pkg::FIFO_AW + 2;

    logic                       accept;
    ddm_pkg::ddm_front_stat_t   stat;
    logic                       push;
    ddm_pkg::ddm_ctl_t          f_ctl;
    logic [NW-1:0]              f_num;
    logic [NW-1:0]              f_den;
    logic [F1-1:0]              f_mag_r;
    logic [F1-1:0]              f_mag_l;

    logic [EW-1:0]              q_din;
    logic [EW-1:0]              q_dout;
    logic                       q_valid;
    logic [ddm_pkg::FIFO_AW:0]  q_count;
    logic                       pop;
    logic [OCW-1:0]             occupancy;

    ddm_pkg::ddm_ctl_t          b_ctl;
    logic [NW-1:0]              b_num;
    logic [NW-1:0]              b_den;
    logic [F1-1:0]              b_mag_r;
    logic [F1-1:0]              b_mag_l;

    logic                       d_valid;
    ddm_pkg::ddm_dir_t          d_dir;
    logic [F1-1:0]              d_mag_r;
    logic [F1-1:0]              d_mag_l;
    ddm_pkg::ddm_dir_t          o_dir;

    // Hold off new items when the queue could not absorb everything in flight.
    assign occupancy = OCW'(q_count) + OCW'(stat.a_valid) + OCW'(stat.b_valid);
    assign busy      = (occupancy >= OCW'(ddm_pkg::FIFO_DEPTH));
    assign accept    = start && !busy;

    ddm_front #(
        .FRAC_BITS (FRAC_BITS),
        .NW        (NW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .turn     (turn),
        .forward  (forward),
        .stat     (stat),
        .push     (push),
        .ctl      (f_ctl),
        .num      (f_num),
        .den      (f_den),
        .mag_r    (f_mag_r),
        .mag_l    (f_mag_l)
    );

    assign q_din = {f_ctl, f_num, f_den, f_mag_r, f_mag_l};

    ddm_fifo #(
        .WIDTH (EW)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .din        (q_din),
        .pop        (pop),
        .dout       (q_dout),
        .dout_valid (q_valid),
        .count      (q_count)
    );

    // The back end never stalls, so it takes an item whenever one waits.
    assign pop = (q_count != '0);
    assign {b_ctl, b_num, b_den, b_mag_r, b_mag_l} = q_dout;

    ddm_div #(
        .FRAC_BITS (FRAC_BITS),
        .NW        (NW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .ctl       (b_ctl),
        .num       (b_num),
        .den       (b_den),
        .mag_r     (b_mag_r),
        .mag_l     (b_mag_l),
        .out_valid (d_valid),
        .dir       (d_dir),
        .mag_r_out (d_mag_r),
        .mag_l_out (d_mag_l)
    );

    ddm_duty #(
        .FRAC_BITS    (FRAC_BITS),
        .TABLE_POINTS (TABLE_POINTS)
    ) u_duty (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (d_valid),
        .dir        (d_dir),
        .mag_r      (d_mag_r),
        .mag_l      (d_mag_l),
        .out_valid  (done),
        .dir_out    (o_dir),
        .right_duty (right_duty),
        .left_duty  (left_duty)
    );

    assign right_backward = o_dir.neg_r;
    assign left_backward  = o_dir.neg_l;

endmodule

/* sim/ddm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddm_checker
// Watches the command and result channels of the mixer. It predicts the duty
// values and direction bits of every accepted command, then compares each
// result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module ddm_checker #(
    parameter int FRAC_BITS    = 8,
    parameter int TABLE_POINTS = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic signed [ddm_pkg::IN_W-1:0]   turn,
    input  logic signed [ddm_pkg::IN_W-1:0]   forward,
    input  logic                              done,
    input  logic [ddm_pkg::DUTY_W-1:0]        right_duty,
    input  logic [ddm_pkg::DUTY_W-1:0]        left_duty,
    input  logic                              right_backward,
    input  logic                              left_backward,
    output int                                fail_count,
    output int                                outstanding
);

    localparam longint UNIT     = longint'(1) << FRAC_BITS;
    localparam int     N_STORED = 5;

    localparam int RIGHT_PTS [N_STORED] = '{139, 154, 198, 335, 600};
    localparam int LEFT_PTS  [N_STORED] = '{187, 194, 235, 390, 750};

    typedef struct packed {
        logic [ddm_pkg::DUTY_W-1:0] right_duty;
        logic [ddm_pkg::DUTY_W-1:0] left_duty;
        logic                       right_backward;
        logic                       left_backward;
    } wheel_cmd_t;

    wheel_cmd_t wheel_cmd_q [$];
    int         mismatches = 0;
    int         waiting    = 0;

    assign fail_count  = mismatches;
    assign outstanding = waiting;

    // Points past the stored table repeat the last stored entry.
    function automatic longint table_point(input bit left_lane, input longint idx);
        longint k;
        k = idx;
        if (k < 0)
        begin
            k = 0;
        end
        if (k > N_STORED - 1)
        begin
            k = N_STORED - 1;
        end
        if (left_lane)
        begin
            return LEFT_PTS[k];
        end
        return RIGHT_PTS[k];
    endfunction

    function automatic logic [ddm_pkg::DUTY_W-1:0] wheel_duty(input bit left_lane,
                                                             input longint speed);
        longint mag;
        longint scaled;
        longint seg;
        longint frac;
        longint base;
        longint d;
        mag = (speed < 0) ? -speed : speed;
        if (mag > UNIT)
        begin
            mag = UNIT;
        end
        scaled = mag * (TABLE_POINTS - 1);
        seg    = scaled / UNIT;
        frac   = scaled - seg * UNIT;
        if (seg >= TABLE_POINTS - 1)
        begin
            d = table_point(left_lane, TABLE_POINTS - 1);
        end
        else
        begin
            base = table_point(left_lane, seg);
            d    = base + ((table_point(left_lane, seg + 1) - base) * frac) / UNIT;
        end
        if (d < 0)
        begin
            d = 0;
        end
        return d[ddm_pkg::DUTY_W-1:0];
    endfunction

    function automatic wheel_cmd_t mix_command(input logic signed [ddm_pkg::IN_W-1:0] t_in,
                                               input logic signed [ddm_pkg::IN_W-1:0] f_in);
        longint     t;
        longint     f;
        longint     pr;
        longint     pl;
        longint     ar;
        longint     al;
        longint     mx;
        longint     r;
        longint     l;
        wheel_cmd_t res;
        t = longint'(t_in);
        f = longint'(f_in);
        if (f == 0)
        begin
            // Spin in place: the turn command goes straight to the wheels.
            l = t;
            r = -t;
        end
        else
        begin
            pr = f * (UNIT - t);
            pl = f * (UNIT + t);
            ar = (pr < 0) ? -pr : pr;
            al = (pl < 0) ? -pl : pl;
            mx = (ar > al) ? ar : al;
            if (mx > UNIT * UNIT)
            begin
                r = (pr * UNIT) / mx;
                l = (pl * UNIT) / mx;
            end
            else
            begin
                r = pr / UNIT;
                l = pl / UNIT;
            end
        end
        res.right_duty     = wheel_duty(1'b0, r);
        res.left_duty      = wheel_duty(1'b1, l);
        res.right_backward = (r < 0);
        res.left_backward  = (l < 0);
        return res;
    endfunction

    task automatic report_field(input string field, input int exp_v, input int act_v);
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
        mismatches = mismatches + 1;
    endtask

    always @(posedge clk)
    begin
        wheel_cmd_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (wheel_cmd_q.size() == 0)
                begin
                    $display("%0t ns: result with no command waiting, expected none, actual %0d %0d %0b %0b",
                             $time, right_duty, left_duty, right_backward, left_backward);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = wheel_cmd_q.pop_front();
                    if (right_duty !== want.right_duty)
                    begin
                        report_field("right_duty", int'(want.right_duty), int'(right_duty));
                    end
                    if (left_duty !== want.left_duty)
                    begin
                        report_field("left_duty", int'(want.left_duty), int'(left_duty));
                    end
                    if (right_backward !== want.right_backward)
                    begin
                        report_field("right_backward", int'(want.right_backward),
                                     int'(right_backward));
                    end
                    if (left_backward !== want.left_backward)
                    begin
                        report_field("left_backward", int'(want.left_backward),
                                     int'(left_backward));
                    end
                end
            end
            if (start && !busy)
            begin
                wheel_cmd_q.push_back(mix_command(turn, forward));
            end
            waiting <= wheel_cmd_q.size();
        end
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives steering and speed commands into the mixer: a directed set of edge
// cases, then random commands under three idling patterns. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

    localparam int FRAC_BITS    = 8;
    localparam int TABLE_POINTS = 5;
    localparam int N_DIRECTED   = 24;

    localparam int DIR_TURN [N_DIRECTED] = '{
        0, 256, -256, 511, -512, 300, -300, 0, 0, 256, -256, 256,
        -256, 511, -512, -512, 511, 128, -100, 1, -1, 1, 64, 0
    };
    localparam int DIR_FWD [N_DIRECTED] = '{
        0, 0, 0, 0, 0, 0, 0, 256, -256, 256, 256, -256,
        -256, 511, -512, 511, -512, 200, -37, 1, -1, 0, 255, 1
    };

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic signed [ddm_pkg::IN_W-1:0]   turn;
    logic signed [ddm_pkg::IN_W-1:0]   forward;
    logic                              done;
    logic [ddm_pkg::DUTY_W-1:0]        right_duty;
    logic [ddm_pkg::DUTY_W-1:0]        left_duty;
    logic                              right_backward;
    logic                              left_backward;
    int                                fail_count;
    int                                outstanding;
    int                                idle_pct;

    diff_drive_mix_to_pwm #(
        .FRAC_BITS    (FRAC_BITS),
        .TABLE_POINTS (TABLE_POINTS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .turn           (turn),
        .forward        (forward),
        .done           (done),
        .right_duty     (right_duty),
        .left_duty      (left_duty),
        .right_backward (right_backward),
        .left_backward  (left_backward)
    );

    ddm_checker #(
        .FRAC_BITS    (FRAC_BITS),
        .TABLE_POINTS (TABLE_POINTS)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .turn           (turn),
        .forward        (forward),
        .done           (done),
        .right_duty     (right_duty),
        .left_duty      (left_duty),
        .right_backward (right_backward),
        .left_backward  (left_backward),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_cmd(input logic signed [ddm_pkg::IN_W-1:0] t,
                            input logic signed [ddm_pkg::IN_W-1:0] f);
        while ($urandom_range(99) < idle_pct)
        begin
            start   <= 1'b0;
            turn    <= ddm_pkg::IN_W'($urandom);
            forward <= ddm_pkg::IN_W'($urandom);
            @(negedge clk);
        end
        start   <= 1'b1;
        turn    <= t;
        forward <= f;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic run_phase(input int count);
        int                              sel;
        logic signed [ddm_pkg::IN_W-1:0] t;
        logic signed [ddm_pkg::IN_W-1:0] f;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            if (sel < 15)
            begin
                // Spin in place, now and then with a turn beyond full scale.
                t = (sel < 3) ? ddm_pkg::IN_W'($urandom)
                              : ddm_pkg::IN_W'($urandom_range(512) - 256);
                f = '0;
            end
            else if (sel < 85)
            begin
                t = ddm_pkg::IN_W'($urandom_range(512) - 256);
                f = ddm_pkg::IN_W'($urandom_range(512) - 256);
            end
            else
            begin
                t = ddm_pkg::IN_W'($urandom);
                f = ddm_pkg::IN_W'($urandom);
            end
            send_cmd(t, f);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        turn     = '0;
        forward  = '0;
        idle_pct = 21;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int n = 0; n < N_DIRECTED; n++)
        begin
            send_cmd(ddm_pkg::IN_W'(DIR_TURN[n]), ddm_pkg::IN_W'(DIR_FWD[n]));
        end
        run_phase(600);
        idle_pct = 88;
        run_phase(450);
        idle_pct = 0;
        run_phase(780);
        start <= 1'b0;

        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (30) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
